[rtl/core/xfme_pkg.sv]
// ----------------------------------------------------------------------------
// xfme_pkg - shared types and constants of the x86 frame mov encoder
// Byte codes of the emitted instructions, request codes and the frame type
// that carries one encoded instruction between the encoder and the emitter.
// ----------------------------------------------------------------------------
package xfme_pkg;

    // request codes
    localparam logic [2:0] OP_MOV_IMM  = 3'd0;
    localparam logic [2:0] OP_MEM_GEN  = 3'd1;
    localparam logic [2:0] OP_LOAD     = 3'd2;
    localparam logic [2:0] OP_STORE    = 3'd3;
    localparam logic [2:0] OP_MOV_RAX  = 3'd4;

    // prefix and opcode bytes
    localparam logic [7:0] REX_PLAIN   = 8'h40;
    localparam logic [7:0] REX_B       = 8'h41;
    localparam logic [7:0] REX_R       = 8'h44;
    localparam logic [7:0] REX_W       = 8'h48;
    localparam logic [7:0] REX_WB      = 8'h49;
    localparam logic [7:0] REX_WR      = 8'h4C;
    localparam logic [7:0] OPSIZE_PFX  = 8'h66;
    localparam logic [7:0] ESC_0F      = 8'h0F;
    localparam logic [7:0] MOVZX_B     = 8'hB6;
    localparam logic [7:0] MOVZX_W     = 8'hB7;
    localparam logic [7:0] MOV_STORE_B = 8'h88;
    localparam logic [7:0] MOV_STORE   = 8'h89;
    localparam logic [7:0] MOV_LOAD    = 8'h8B;
    localparam logic [7:0] MOV_IMM_OP  = 8'hB8;

    // ModRM bases: [rbp+disp8], [rbp+disp32], register direct
    localparam logic [7:0] MODRM_D8    = 8'h45;
    localparam logic [7:0] MODRM_D32   = 8'h85;
    localparam logic [7:0] MODRM_REG   = 8'hC0;

    localparam int unsigned FRAME_BYTES = 10;
    localparam int unsigned COUNT_W     = 4;

    // largest offset whose negation still fits in disp8
    localparam logic [30:0] DISP8_MAX_OFF = 31'd128;

    typedef struct packed {
        logic [FRAME_BYTES-1:0][7:0] bytes;
        logic [COUNT_W-1:0]          count;
    } frame_t;

endpackage

[rtl/core/xfme_encoder.sv]
// ----------------------------------------------------------------------------
// xfme_encoder - instruction byte builder
// Turns one registered request into a frame of up to ten code bytes, low
// byte first, and the number of valid bytes.
// ----------------------------------------------------------------------------
module xfme_encoder (
    input  logic [2:0]       op,
    input  logic [3:0]       register_number,
    input  logic [63:0]      immediate,
    input  logic [30:0]      frame_offset,
    input  logic [3:0]       access_size,
    input  logic [7:0]       opcode,
    output xfme_pkg::frame_t frame
);

    logic [2:0]       low;
    logic             hi;
    logic [7:0]       rexw;
    logic [31:0]      neg;
    logic             sd;
    logic [7:0]       modrm;
    logic [3:0][7:0]  head;
    logic [1:0]       hn;
    logic [7:0][7:0]  tail;
    logic [3:0]       tn;
    logic             mem_tail;
    logic [3:0]       idx;

    assign low   = register_number[2:0];
    assign hi    = register_number[3];
    assign rexw  = hi ? xfme_pkg::REX_WR : xfme_pkg::REX_W;
    assign neg   = 32'd0 - {1'b0, frame_offset};
    assign sd    = (frame_offset <= xfme_pkg::DISP8_MAX_OFF);
    assign modrm = (sd ? xfme_pkg::MODRM_D8 : xfme_pkg::MODRM_D32) | {2'b00, low, 3'b000};

    // prefix/opcode head and immediate tail
    always_comb
    begin
        head     = '0;
        hn       = 2'd0;
        tail     = '0;
        tn       = 4'd0;
        mem_tail = 1'b0;
        case (op)
            xfme_pkg::OP_MOV_IMM:
            begin
                if (immediate[63:32] == 32'd0)
                begin
                    if (hi)
                    begin
                        head[0] = xfme_pkg::REX_B;
                        head[1] = xfme_pkg::MOV_IMM_OP + {5'd0, low};
                        hn      = 2'd2;
                    end
                    else
                    begin
                        head[0] = xfme_pkg::MOV_IMM_OP + {5'd0, low};
                        hn      = 2'd1;
                    end
                    tail[3:0] = immediate[31:0];
                    tn        = 4'd4;
                end
                else
                begin
                    head[0] = hi ? xfme_pkg::REX_WB : xfme_pkg::REX_W;
                    head[1] = xfme_pkg::MOV_IMM_OP + {5'd0, low};
                    hn      = 2'd2;
                    tail    = immediate;
                    tn      = 4'd8;
                end
            end
            xfme_pkg::OP_MEM_GEN:
            begin
                head[0]  = rexw;
                head[1]  = opcode;
                hn       = 2'd2;
                mem_tail = 1'b1;
            end
            xfme_pkg::OP_LOAD:
            begin
                mem_tail = 1'b1;
                if (access_size == 4'd1 || access_size == 4'd2)
                begin
                    head[0] = rexw;
                    head[1] = xfme_pkg::ESC_0F;
                    head[2] = (access_size == 4'd1) ? xfme_pkg::MOVZX_B : xfme_pkg::MOVZX_W;
                    hn      = 2'd3;
                end
                else if (access_size == 4'd4)
                begin
                    if (hi)
                    begin
                        head[0] = xfme_pkg::REX_R;
                        head[1] = xfme_pkg::MOV_LOAD;
                        hn      = 2'd2;
                    end
                    else
                    begin
                        head[0] = xfme_pkg::MOV_LOAD;
                        hn      = 2'd1;
                    end
                end
                else
                begin
                    head[0] = rexw;
                    head[1] = xfme_pkg::MOV_LOAD;
                    hn      = 2'd2;
                end
            end
            xfme_pkg::OP_STORE:
            begin
                mem_tail = 1'b1;
                if (access_size == 4'd1)
                begin
                    if (hi || register_number[2])
                    begin
                        head[0] = hi ? xfme_pkg::REX_R : xfme_pkg::REX_PLAIN;
                        head[1] = xfme_pkg::MOV_STORE_B;
                        hn      = 2'd2;
                    end
                    else
                    begin
                        head[0] = xfme_pkg::MOV_STORE_B;
                        hn      = 2'd1;
                    end
                end
                else if (access_size == 4'd2)
                begin
                    head[0] = xfme_pkg::OPSIZE_PFX;
                    if (hi)
                    begin
                        head[1] = xfme_pkg::REX_R;
                        head[2] = xfme_pkg::MOV_STORE;
                        hn      = 2'd3;
                    end
                    else
                    begin
                        head[1] = xfme_pkg::MOV_STORE;
                        hn      = 2'd2;
                    end
                end
                else if (access_size == 4'd4)
                begin
                    if (hi)
                    begin
                        head[0] = xfme_pkg::REX_R;
                        head[1] = xfme_pkg::MOV_STORE;
                        hn      = 2'd2;
                    end
                    else
                    begin
                        head[0] = xfme_pkg::MOV_STORE;
                        hn      = 2'd1;
                    end
                end
                else
                begin
                    head[0] = rexw;
                    head[1] = xfme_pkg::MOV_STORE;
                    hn      = 2'd2;
                end
            end
            xfme_pkg::OP_MOV_RAX:
            begin
                // copy rax into rax encodes to nothing
                if (register_number != 4'd0)
                begin
                    head[0] = hi ? xfme_pkg::REX_WB : xfme_pkg::REX_W;
                    head[1] = xfme_pkg::MOV_STORE;
                    head[2] = xfme_pkg::MODRM_REG | {5'd0, low};
                    hn      = 2'd3;
                end
            end
            default:
            begin
                hn = 2'd0;
            end
        endcase

        // ModRM plus displacement for the rbp-relative forms
        if (mem_tail)
        begin
            tail[0] = modrm;
            if (sd)
            begin
                tail[1] = neg[7:0];
                tn      = 4'd2;
            end
            else
            begin
                tail[4:1] = neg;
                tn        = 4'd5;
            end
        end
    end

    // splice head and tail into the frame
    always_comb
    begin
        idx = 4'd0;
        for (int i = 0; i < xfme_pkg::FRAME_BYTES; i++)
        begin
            idx = 4'(i) - {2'b00, hn};
            if (4'(i) < {2'b00, hn})
                frame.bytes[i] = head[2'(i)];
            else if (idx < 4'd8)
                frame.bytes[i] = tail[idx[2:0]];
            else
                frame.bytes[i] = 8'h00;
        end
        frame.count = {2'b00, hn} + tn;
    end

endmodule

[rtl/core/x86_frame_mov_encoder_unit.sv]
// ----------------------------------------------------------------------------
// x86_frame_mov_encoder_unit - x86-64 frame move encoder
// Encodes one request per transfer into its machine-code bytes and streams
// them out one byte per cycle, the final byte flagged.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload
//  -------   ----------------   ---------------------------------------------
//  request   start / busy       op, register_number, immediate, frame_offset,
//                               access_size, opcode
//  result    strobe (no stall)  code_byte, last_byte
//
//  A request transfers on a clock edge with start high and busy low; it lands
//  in the request register, is encoded combinationally from there and loaded
//  into the frame register once that is free, whose first byte then shows.
//  An item has 0 to 10 bytes and occupies the output one byte a cycle, set
//  by the single result port; an item with no bytes only passes through
//  the request register. The next request is taken while the current
//  frame drains, so items stream with no gap between their bytes.
//  Reset clears the request valid flag and the frame byte count; payload
//  registers are not reset. The receiver cannot stall: each byte is
//  presented for exactly one cycle.
//
module x86_frame_mov_encoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [3:0]  register_number,
    input  logic [63:0] immediate,
    input  logic [30:0] frame_offset,
    input  logic [3:0]  access_size,
    input  logic [7:0]  opcode,
    output logic        strobe,
    output logic [7:0]  code_byte,
    output logic        last_byte
);

    // request register
    logic        req_valid_reg, req_valid_next;
    logic [2:0]  op_reg;
    logic [3:0]  reg_num_reg;
    logic [63:0] imm_reg;
    logic [30:0] offset_reg;
    logic [3:0]  size_reg;
    logic [7:0]  opcode_reg;

    // frame register (shift-out)
    logic [xfme_pkg::FRAME_BYTES-1:0][7:0] bytes_reg, bytes_next;
    logic [xfme_pkg::COUNT_W-1:0]          count_reg, count_next;

    xfme_pkg::frame_t enc_frame;
    logic             accept;
    logic             frame_load;

    // frame register is free when empty or sending its final byte
    assign frame_load = (count_reg <= 4'd1);
    assign busy       = req_valid_reg && !frame_load;
    assign accept     = start && !busy;

    xfme_encoder u_encoder (
        .op              (op_reg),
        .register_number (reg_num_reg),
        .immediate       (imm_reg),
        .frame_offset    (offset_reg),
        .access_size     (size_reg),
        .opcode          (opcode_reg),
        .frame           (enc_frame)
    );

    // hold the request until the frame register takes it
    always_comb
    begin
        if (accept)
            req_valid_next = 1'b1;
        else if (frame_load)
            req_valid_next = 1'b0;
        else
            req_valid_next = req_valid_reg;
    end

    // load a new frame or advance the current one by a byte
    always_comb
    begin
        if (frame_load && req_valid_reg)
        begin
            bytes_next = enc_frame.bytes;
            count_next = enc_frame.count;
        end
        else if (count_reg != 4'd0)
        begin
            bytes_next = {8'h00, bytes_reg[xfme_pkg::FRAME_BYTES-1:1]};
            count_next = count_reg - 4'd1;
        end
        else
        begin
            bytes_next = bytes_reg;
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= op;
            reg_num_reg <= register_number;
            imm_reg     <= immediate;
            offset_reg  <= frame_offset;
            size_reg    <= access_size;
            opcode_reg  <= opcode;
        end
        bytes_reg <= bytes_next;
    end

    assign strobe    = (count_reg != 4'd0);
    assign code_byte = bytes_reg[0];
    assign last_byte = (count_reg == 4'd1);

    // a frame drains without gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last_byte) |=> strobe)
        else $error("byte stream broke inside an instruction");

    // busy only with a pending request
    a_busy_pending: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> req_valid_reg)
        else $error("busy raised with no pending request");

    // a transfer always leaves a pending request
    a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> req_valid_reg)
        else $error("accepted request lost");

    // the frame never holds more than ten bytes
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 4'd10)
        else $error("frame byte count out of range");

endmodule

[tb/x86_frame_mov_encoder_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// x86_frame_mov_encoder_unit_tb - self-checking bench for the frame mov encoder
// Sends directed and random encode requests through the start/busy port, works
// out the machine-code bytes of each one and checks every byte strobed out,
// including the last-byte flag, in order against that expected stream.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  register_number;
    logic [63:0] immediate;
    logic [30:0] frame_offset;
    logic [3:0]  access_size;
    logic [7:0]  opcode;
} request_t;

typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
} code_entry_t;

class code_scoreboard;
    code_entry_t pending_bytes[$];
    int unsigned mismatches;
    int unsigned requests_noted;
    int unsigned bytes_checked;

    function new();
        mismatches     = 0;
        requests_noted = 0;
        bytes_checked  = 0;
    endfunction

    function int unsigned pending();
        return pending_bytes.size();
    endfunction

    task report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    // Encode one accepted request and queue its bytes, last one flagged.
    task note_request(input request_t r);
        logic [7:0]  seq[$];
        logic [2:0]  low;
        logic        hi;
        logic [7:0]  rex_wide;
        logic [31:0] disp;
        logic        short_disp;
        logic        frame_operand;
        logic [7:0]  modrm;
        code_entry_t entry;

        low           = r.register_number[2:0];
        hi            = r.register_number[3];
        rex_wide      = hi ? xfme_pkg::REX_WR : xfme_pkg::REX_W;
        disp          = 32'd0 - {1'b0, r.frame_offset};
        short_disp    = (r.frame_offset <= xfme_pkg::DISP8_MAX_OFF);
        frame_operand = 1'b0;
        requests_noted++;

        case (r.op)
            xfme_pkg::OP_MOV_IMM:
            begin
                if (r.immediate[63:32] == 32'd0)
                begin
                    if (hi)
                        seq.push_back(xfme_pkg::REX_B);
                    seq.push_back(xfme_pkg::MOV_IMM_OP + {5'd0, low});
                    for (int i = 0; i < 4; i++)
                        seq.push_back(r.immediate[8*i +: 8]);
                end
                else
                begin
                    seq.push_back(hi ? xfme_pkg::REX_WB : xfme_pkg::REX_W);
                    seq.push_back(xfme_pkg::MOV_IMM_OP + {5'd0, low});
                    for (int i = 0; i < 8; i++)
                        seq.push_back(r.immediate[8*i +: 8]);
                end
            end
            xfme_pkg::OP_MEM_GEN:
            begin
                seq.push_back(rex_wide);
                seq.push_back(r.opcode);
                frame_operand = 1'b1;
            end
            xfme_pkg::OP_LOAD:
            begin
                if (r.access_size == 4'd1 || r.access_size == 4'd2)
                begin
                    seq.push_back(rex_wide);
                    seq.push_back(xfme_pkg::ESC_0F);
                    seq.push_back(r.access_size == 4'd1 ? xfme_pkg::MOVZX_B
                                                        : xfme_pkg::MOVZX_W);
                end
                else if (r.access_size == 4'd4)
                begin
                    if (hi)
                        seq.push_back(xfme_pkg::REX_R);
                    seq.push_back(xfme_pkg::MOV_LOAD);
                end
                else
                begin
                    seq.push_back(rex_wide);
                    seq.push_back(xfme_pkg::MOV_LOAD);
                end
                frame_operand = 1'b1;
            end
            xfme_pkg::OP_STORE:
            begin
                if (r.access_size == 4'd1)
                begin
                    // spl/bpl/sil/dil need an empty REX
                    if (hi)
                        seq.push_back(xfme_pkg::REX_R);
                    else if (r.register_number >= 4'd4)
                        seq.push_back(xfme_pkg::REX_PLAIN);
                    seq.push_back(xfme_pkg::MOV_STORE_B);
                end
                else if (r.access_size == 4'd2 || r.access_size == 4'd4)
                begin
                    if (r.access_size == 4'd2)
                        seq.push_back(xfme_pkg::OPSIZE_PFX);
                    if (hi)
                        seq.push_back(xfme_pkg::REX_R);
                    seq.push_back(xfme_pkg::MOV_STORE);
                end
                else
                begin
                    seq.push_back(rex_wide);
                    seq.push_back(xfme_pkg::MOV_STORE);
                end
                frame_operand = 1'b1;
            end
            xfme_pkg::OP_MOV_RAX:
            begin
                if (r.register_number != 4'd0)
                begin
                    seq.push_back(hi ? xfme_pkg::REX_WB : xfme_pkg::REX_W);
                    seq.push_back(xfme_pkg::MOV_STORE);
                    seq.push_back(xfme_pkg::MODRM_REG | {5'd0, low});
                end
            end
            default:
            begin
            end
        endcase

        if (frame_operand)
        begin
            modrm = short_disp ? xfme_pkg::MODRM_D8 : xfme_pkg::MODRM_D32;
            seq.push_back(modrm | {2'b00, low, 3'b000});
            if (short_disp)
                seq.push_back(disp[7:0]);
            else
                for (int i = 0; i < 4; i++)
                    seq.push_back(disp[8*i +: 8]);
        end

        foreach (seq[i])
        begin
            entry.code_byte = seq[i];
            entry.last_byte = (i == seq.size() - 1);
            pending_bytes.push_back(entry);
        end
    endtask

    task check_byte(input logic [7:0] code_byte, input logic last_byte);
        code_entry_t want;

        bytes_checked++;
        if (pending_bytes.size() == 0)
        begin
            report_mismatch($sformatf("byte %02h strobed with nothing expected", code_byte));
            return;
        end
        want = pending_bytes.pop_front();
        if (code_byte !== want.code_byte)
            report_mismatch($sformatf("code_byte %02h, expected %02h (byte %0d)",
                                      code_byte, want.code_byte, bytes_checked));
        if (last_byte !== want.last_byte)
            report_mismatch($sformatf("last_byte %0b, expected %0b (byte %0d)",
                                      last_byte, want.last_byte, bytes_checked));
    endtask

    task report_leftover();
        code_entry_t left;

        while (pending_bytes.size() != 0)
        begin
            left = pending_bytes.pop_front();
            report_mismatch($sformatf("expected byte %02h never came", left.code_byte));
        end
    endtask
endclass

module x86_frame_mov_encoder_unit_tb;

    // highest value the 3-bit request field can carry; codes above
    // OP_MOV_RAX are reserved and must be dropped by the block
    localparam logic [2:0] OP_CODE_TOP = 3'd7;

    localparam int unsigned RANDOM_ITEMS  = 175;  // counted (non-reserved) requests
    localparam int unsigned QUIET_TAIL    = 40;   // last requests sent back to back
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam int unsigned CYCLE_LIMIT   = 200000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  op;
    logic [3:0]  register_number;
    logic [63:0] immediate;
    logic [30:0] frame_offset;
    logic [3:0]  access_size;
    logic [7:0]  opcode;
    logic        strobe;
    logic [7:0]  code_byte;
    logic        last_byte;

    code_scoreboard sb;
    int unsigned    cycle_count;

    x86_frame_mov_encoder_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .register_number (register_number),
        .immediate       (immediate),
        .frame_offset    (frame_offset),
        .access_size     (access_size),
        .opcode          (opcode),
        .strobe          (strobe),
        .code_byte       (code_byte),
        .last_byte       (last_byte)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Guard against a hung block: count every cycle and bail out far past
    // the slowest correct run.
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Check each strobed byte at the edge that ends its cycle; the receiver
    // never stalls, so every strobe is a transfer.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_byte(code_byte, last_byte);
    end

    function automatic request_t make_request(input logic [2:0] r_op,
                                              input logic [3:0] r_reg,
                                              input logic [63:0] r_imm,
                                              input logic [30:0] r_off,
                                              input logic [3:0] r_size,
                                              input logic [7:0] r_opc);
        request_t r;

        r.op              = r_op;
        r.register_number = r_reg;
        r.immediate       = r_imm;
        r.frame_offset    = r_off;
        r.access_size     = r_size;
        r.opcode          = r_opc;
        return r;
    endfunction

    // Build one random request. Keep most offsets near the disp8/disp32 edge
    // and most immediates near the imm32/imm64 edge, with full-width noise
    // mixed in so every field bit toggles.
    function automatic request_t random_request();
        request_t r;

        if ($urandom_range(0, 19) != 0)
            r.op = 3'($urandom_range(xfme_pkg::OP_MOV_IMM, xfme_pkg::OP_MOV_RAX));
        else
            r.op = 3'($urandom_range(xfme_pkg::OP_MOV_RAX + 1, OP_CODE_TOP));
        r.register_number = 4'($urandom());
        case ($urandom_range(0, 4))
            0:       r.immediate = {32'd0, 32'($urandom())};
            1:       r.immediate = 64'h0000_0000_FFFF_FFFF;
            2:       r.immediate = 64'h0000_0001_0000_0000;
            3:       r.immediate = {32'($urandom_range(1, 255)), 32'($urandom())};
            default: r.immediate = {32'($urandom()), 32'($urandom())};
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3: r.frame_offset = 31'($urandom_range(0, 160));
            4, 5:       r.frame_offset = 31'($urandom_range(126, 130));
            6:          r.frame_offset = 31'h7FFF_FFFF;
            default:    r.frame_offset = 31'($urandom());
        endcase
        case ($urandom_range(0, 9))
            0, 1:    r.access_size = 4'd1;
            2, 3:    r.access_size = 4'd2;
            4, 5:    r.access_size = 4'd4;
            6:       r.access_size = 4'd8;
            default: r.access_size = 4'($urandom());
        endcase
        r.opcode = 8'($urandom());
        return r;
    endfunction

    // Present one request from the falling edge and hold it until a rising
    // edge sees busy low; that edge is the transfer.
    task send_request(input request_t r);
        @(negedge clk);
        start           <= 1'b1;
        op              <= r.op;
        register_number <= r.register_number;
        immediate       <= r.immediate;
        frame_offset    <= r.frame_offset;
        access_size     <= r.access_size;
        opcode          <= r.opcode;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(r);
    endtask

    // Drop start and scramble the payload while idle so the block
    // has to ignore it.
    task hold_idle(input int unsigned cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            start           <= 1'b0;
            op              <= 3'($urandom());
            register_number <= 4'($urandom());
            immediate       <= {32'($urandom()), 32'($urandom())};
            frame_offset    <= 31'($urandom());
            access_size     <= 4'($urandom());
            opcode          <= 8'($urandom());
        end
    endtask

    initial
    begin
        request_t    r;
        int unsigned counted;
        bit          drained_once;

        sb              = new();
        rst_n           = 1'b0;
        start           = 1'b0;
        op              = xfme_pkg::OP_MOV_IMM;
        register_number = 4'd0;
        immediate       = 64'd0;
        frame_offset    = 31'd0;
        access_size     = 4'd0;
        opcode          = 8'd0;
        counted         = 0;
        drained_once    = 1'b0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: immediate form edges, disp8/disp32 edges, every load and
        // store width with a mix of low, byte-register and extended registers,
        // the no-byte move of rax into itself and the reserved request codes.
        send_request(make_request(xfme_pkg::OP_MOV_IMM, 4'd0, 64'd0,
                                  31'd0, 4'd0, 8'h00));
        send_request(make_request(xfme_pkg::OP_MOV_IMM, 4'd15, 64'h0000_0000_FFFF_FFFF,
                                  31'd0, 4'd0, 8'h00));
        send_request(make_request(xfme_pkg::OP_MOV_IMM, 4'd7, 64'h0000_0001_0000_0000,
                                  31'd0, 4'd0, 8'h00));
        send_request(make_request(xfme_pkg::OP_MOV_IMM, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF,
                                  31'd0, 4'd0, 8'h00));
        send_request(make_request(xfme_pkg::OP_MEM_GEN, 4'd3, 64'd0,
                                  31'd0, 4'd0, 8'h00));
        send_request(make_request(xfme_pkg::OP_MEM_GEN, 4'd12, 64'd0,
                                  31'd128, 4'd0, 8'hFF));
        send_request(make_request(xfme_pkg::OP_MEM_GEN, 4'd5, 64'd0,
                                  31'd129, 4'd0, 8'h03));
        send_request(make_request(xfme_pkg::OP_MEM_GEN, 4'd15, 64'd0,
                                  31'h7FFF_FFFF, 4'd0, 8'h8D));
        send_request(make_request(xfme_pkg::OP_LOAD, 4'd2, 64'd0, 31'd8, 4'd1, 8'h00));
        send_request(make_request(xfme_pkg::OP_LOAD, 4'd9, 64'd0, 31'd200, 4'd2, 8'h00));
        send_request(make_request(xfme_pkg::OP_LOAD, 4'd4, 64'd0, 31'd16, 4'd4, 8'h00));
        send_request(make_request(xfme_pkg::OP_LOAD, 4'd13, 64'd0, 31'd128, 4'd4, 8'h00));
        send_request(make_request(xfme_pkg::OP_LOAD, 4'd0, 64'd0, 31'd1, 4'd8, 8'h00));
        send_request(make_request(xfme_pkg::OP_LOAD, 4'd10, 64'd0, 31'd64, 4'd0, 8'h00));
        send_request(make_request(xfme_pkg::OP_LOAD, 4'd6, 64'd0, 31'd4096, 4'd15, 8'h00));
        send_request(make_request(xfme_pkg::OP_STORE, 4'd3, 64'd0, 31'd24, 4'd1, 8'h00));
        send_request(make_request(xfme_pkg::OP_STORE, 4'd4, 64'd0, 31'd32, 4'd1, 8'h00));
        send_request(make_request(xfme_pkg::OP_STORE, 4'd11, 64'd0, 31'd300, 4'd1, 8'h00));
        send_request(make_request(xfme_pkg::OP_STORE, 4'd1, 64'd0, 31'd2, 4'd2, 8'h00));
        send_request(make_request(xfme_pkg::OP_STORE, 4'd14, 64'd0,
                                  31'h4000_0000, 4'd2, 8'h00));
        send_request(make_request(xfme_pkg::OP_STORE, 4'd8, 64'd0, 31'd127, 4'd4, 8'h00));
        send_request(make_request(xfme_pkg::OP_STORE, 4'd15, 64'd0, 31'd40, 4'd9, 8'h00));
        send_request(make_request(xfme_pkg::OP_MOV_RAX, 4'd0, 64'd0, 31'd0, 4'd0, 8'h00));
        send_request(make_request(xfme_pkg::OP_MOV_RAX, 4'd9, 64'd0, 31'd0, 4'd0, 8'h00));
        send_request(make_request(xfme_pkg::OP_MOV_RAX + 3'd1, 4'd1, 64'd0,
                                  31'd0, 4'd0, 8'h00));
        send_request(make_request(OP_CODE_TOP, 4'd2, 64'd0, 31'd0, 4'd0, 8'h00));

        // Random part: gaps in bursts early on, back-to-back at the tail,
        // and one full drain halfway through.
        while (counted < RANDOM_ITEMS)
        begin
            if (!drained_once && counted == RANDOM_ITEMS / 2)
            begin
                @(negedge clk);
                start <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
                drained_once = 1'b1;
            end
            if (counted < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
                hold_idle($urandom_range(1, 4));
            r = random_request();
            send_request(r);
            if (r.op <= xfme_pkg::OP_MOV_RAX)
                counted++;
        end

        @(negedge clk);
        start <= 1'b0;

        // Let the last frame drain, then keep clocking the block so that any
        // stray byte shows.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.report_leftover();

        $display("Run covered %0d requests of every kind (imm32/imm64, disp8/disp32,",
                 sb.requests_noted);
        $display("all access widths, reserved codes) and %0d strobed bytes.",
                 sb.bytes_checked);
        if (sb.mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
